@@ hdl/iqm_pkg.sv @@
// shared types, constants and fixed-point helpers of the iq mismatch solver
// no dependencies; imported by iqm_div and iq_mismatch_coeff_solver
package iqm_pkg;

   typedef logic signed [31:0] s32_type;
   typedef logic signed [12:0] f13_type;
   typedef logic signed [13:0] corr_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ZERO_POWER = 3'd1,
      ST_RANGE      = 3'd2,
      ST_ZERO_MAG   = 3'd3,
      ST_SINGULAR   = 3'd4,
      ST_TX_DIV0    = 3'd5,
      ST_RX_DIV0    = 3'd6
   } status_type;

   // divider geometry: one quotient bit per stage plus an input stage
   localparam int DIV_W   = 32;
   localparam int DIV_LAT = DIV_W + 1;

   localparam int NUM_RATIO = 8;

   localparam s32_type Q15_ONE     = 32'sd32768;
   localparam int      RES_SHIFT   = 15;
   localparam int      SC_GAIN_SHIFT = 8;
   localparam int      DELPT_DIV   = 5;
   localparam f13_type P00_MIN     = 13'sd1024;
   localparam f13_type P00_MAX     = 13'sd2047;
   localparam s32_type CLAMP_HI    = 32'sd63;
   localparam s32_type CLAMP_LO    = -32'sd63;
   localparam logic [11:0] SIGN_THR = 12'h800;

   // 12-bit field, values above the threshold map to value - 4096
   function automatic f13_type sext12(input logic [11:0] v);
      return (v > SIGN_THR) ? f13_type'({1'b1, v}) : f13_type'({1'b0, v});
   endfunction

   // signed division by 2^n truncating toward zero
   function automatic s32_type div_pow2(input s32_type v, input int n);
      s32_type bias;
      bias = (32'sd1 <<< n) - 32'sd1;
      return v[31] ? ((v + bias) >>> n) : (v >>> n);
   endfunction

   function automatic s32_type abs32(input s32_type v);
      return v[31] ? -v : v;
   endfunction

   function automatic s32_type clamp63(input s32_type v);
      s32_type r;
      r = v;
      if (v < CLAMP_LO) r = CLAMP_LO;
      if (v > CLAMP_HI) r = CLAMP_HI;
      return r;
   endfunction

   // alpha-max-beta-min magnitude estimate
   function automatic s32_type mag_approx(input s32_type re, input s32_type im);
      s32_type ai, aq, mx, mn;
      ai = abs32(re);
      aq = abs32(im);
      if (ai > aq) begin
         mx = ai;
         mn = aq;
      end else begin
         mx = aq;
         mn = ai;
      end
      return mx - div_pow2(mx, 5) + div_pow2(mn, 3) + div_pow2(mn, 2);
   endfunction

   // q in the upper seven bits, low seven bits of i below
   function automatic corr_type pack_corr(input s32_type mag, input s32_type phs);
      s32_type q, i;
      q = clamp63(div_pow2(mag <<< 7, RES_SHIFT));
      i = clamp63(div_pow2(phs <<< 8, RES_SHIFT));
      return corr_type'({q[6:0], i[6:0]});
   endfunction

endpackage

@@ hdl/iqm_div.sv @@
// pipelined 32-bit signed divider, one quotient bit per stage, truncating
// depends on iqm_pkg; zero divisor gives zero, wraps like 32-bit c
module iqm_div (
   input  logic            clock,
   input  logic            en,
   input  iqm_pkg::s32_type num,
   input  iqm_pkg::s32_type den,
   output iqm_pkg::s32_type quo
);
   import iqm_pkg::*;

   logic [DIV_W-1:0] rem_ff [DIV_LAT];
   logic [DIV_W-1:0] rem_in [DIV_LAT];
   logic [DIV_W-1:0] n_ff   [DIV_LAT];
   logic [DIV_W-1:0] n_in   [DIV_LAT];
   logic [DIV_W-1:0] d_ff   [DIV_LAT];
   logic [DIV_W-1:0] d_in   [DIV_LAT];
   logic             neg_ff [DIV_LAT];
   logic             neg_in [DIV_LAT];
   logic             zero_ff[DIV_LAT];
   logic             zero_in[DIV_LAT];

   // input stage takes magnitudes, then restoring steps
   always_comb begin
      logic [DIV_W:0] rs;
      logic [DIV_W:0] diff;
      rem_in[0]  = '0;
      n_in[0]    = num[DIV_W-1] ? (~num + 1'b1) : num;
      d_in[0]    = den[DIV_W-1] ? (~den + 1'b1) : den;
      neg_in[0]  = num[DIV_W-1] ^ den[DIV_W-1];
      zero_in[0] = (den == '0);
      for (int k = 1; k < DIV_LAT; k++) begin
         rs   = {rem_ff[k-1], n_ff[k-1][DIV_W-1]};
         diff = rs - {1'b0, d_ff[k-1]};
         if (!diff[DIV_W]) begin
            rem_in[k] = diff[DIV_W-1:0];
            n_in[k]   = {n_ff[k-1][DIV_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rs[DIV_W-1:0];
            n_in[k]   = {n_ff[k-1][DIV_W-2:0], 1'b0};
         end
         d_in[k]    = d_ff[k-1];
         neg_in[k]  = neg_ff[k-1];
         zero_in[k] = zero_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            rem_ff[k]  <= rem_in[k];
            n_ff[k]    <= n_in[k];
            d_ff[k]    <= d_in[k];
            neg_ff[k]  <= neg_in[k];
            zero_ff[k] <= zero_in[k];
         end
      end
   end

   // sign of the quotient applied at the tail
   always_comb begin
      if (zero_ff[DIV_LAT-1]) begin
         quo = '0;
      end else if (neg_ff[DIV_LAT-1]) begin
         quo = s32_type'(~n_ff[DIV_LAT-1] + 1'b1);
      end else begin
         quo = s32_type'(n_ff[DIV_LAT-1]);
      end
   end

endmodule

@@ hdl/iq_mismatch_coeff_solver.sv @@
// top level of the iq mismatch coefficient solver pipeline
// depends on iqm_pkg and iqm_div
//
// Takes one packed six-word calibration record per item and returns one
// result item: transmit and receive correction words and a status code.
// The pipeline accepts a new item every cycle while it is not stalled. Each
// item passes through registered stages interleaved with four divider
// banks in series (ratios, normalization, mismatch solve, correction), each
// a 33-stage one-bit-per-stage divider. A stall on the result side while a
// result is held freezes the whole pipeline; req_stall follows it in the same cycle.
module iq_mismatch_coeff_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word_a0_d0_lo,
   input  logic [15:0] req_word_a0_d0_hi,
   input  logic [31:0] req_word_a0_d1,
   input  logic [15:0] req_word_a1_d0_hi,
   input  logic [31:0] req_word_a1_d1,
   input  logic [15:0] req_word_a1_d1_hi,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output iqm_pkg::corr_type rsp_tx_correction,
   output iqm_pkg::corr_type rsp_rx_correction,
   output logic [2:0]  rsp_status
);
   import iqm_pkg::*;

   logic en;

   // ---------------- stage 1: unpack and screen ----------------
   f13_type m00, p00, c00, m01, p01, c01, m10, p10, c10, m11, p11, c11;
   status_type st1_in, st1_ff;
   s32_type num1_in [NUM_RATIO];
   s32_type den1_in [NUM_RATIO];
   s32_type num1_ff [NUM_RATIO];
   s32_type den1_ff [NUM_RATIO];
   logic    v1_ff;

   always_comb begin
      m00 = sext12(req_word_a0_d0_lo[11:0]);
      p00 = sext12(req_word_a0_d0_lo[23:12]);
      c00 = sext12({req_word_a0_d0_hi[3:0], req_word_a0_d0_lo[31:24]});
      m01 = sext12(req_word_a0_d0_hi[15:4]);
      p01 = f13_type'({1'b0, req_word_a0_d1[11:0]});
      c01 = sext12(req_word_a0_d1[23:12]);
      m10 = sext12({req_word_a1_d0_hi[3:0], req_word_a0_d1[31:24]});
      p10 = sext12(req_word_a1_d0_hi[15:4]);
      c10 = sext12(req_word_a1_d1[11:0]);
      m11 = sext12(req_word_a1_d1[23:12]);
      p11 = sext12({req_word_a1_d1_hi[3:0], req_word_a1_d1[31:24]});
      c11 = sext12(req_word_a1_d1_hi[15:4]);

      if (p00 == '0 || p01 == '0 || p10 == '0 || p11 == '0) begin
         st1_in = ST_ZERO_POWER;
      end else if (p00 < P00_MIN || p00 > P00_MAX || p10 < 0 || p11 < 0 ||
                   p00 <= m00 || p00 <= c00 || p01 <= m01 || p01 <= c01 ||
                   p10 <= m10 || p10 <= c10 || p11 <= m11 || p11 <= c11) begin
         st1_in = ST_RANGE;
      end else begin
         st1_in = ST_OK;
      end

      num1_in[0] = s32_type'(m00) <<< RES_SHIFT;
      num1_in[1] = s32_type'(c00) <<< RES_SHIFT;
      num1_in[2] = s32_type'(m01) <<< RES_SHIFT;
      num1_in[3] = s32_type'(c01) <<< RES_SHIFT;
      num1_in[4] = s32_type'(m10) <<< RES_SHIFT;
      num1_in[5] = s32_type'(c10) <<< RES_SHIFT;
      num1_in[6] = s32_type'(m11) <<< RES_SHIFT;
      num1_in[7] = s32_type'(c11) <<< RES_SHIFT;
      den1_in[0] = s32_type'(p00);
      den1_in[1] = s32_type'(p00);
      den1_in[2] = s32_type'(p01);
      den1_in[3] = s32_type'(p01);
      den1_in[4] = s32_type'(p10);
      den1_in[5] = s32_type'(p10);
      den1_in[6] = s32_type'(p11);
      den1_in[7] = s32_type'(p11);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff <= st1_in;
         for (int k = 0; k < NUM_RATIO; k++) begin
            num1_ff[k] <= num1_in[k];
            den1_ff[k] <= den1_in[k];
         end
      end
   end

   // ---------------- divider bank 1: q15 ratios ----------------
   s32_type    quo1 [NUM_RATIO];
   logic       vd1_ff [DIV_LAT];
   status_type std1_ff[DIV_LAT];

   for (genvar g = 0; g < NUM_RATIO; g++) begin : g_ratio
      iqm_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num1_ff[g]),
         .den   (den1_ff[g]),
         .quo   (quo1[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vd1_ff[k] <= 1'b0;
      end else if (en) begin
         vd1_ff[0] <= v1_ff;
         for (int k = 1; k < DIV_LAT; k++) vd1_ff[k] <= vd1_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         std1_ff[0] <= st1_ff;
         for (int k = 1; k < DIV_LAT; k++) std1_ff[k] <= std1_ff[k-1];
      end
   end

   // ---------------- stage 2: sin/cos of 2phi ----------------
   logic       v2_ff;
   status_type st2_ff;
   s32_type    s1_2_ff, c1_2_ff, s2_2_ff, c2_2_ff;
   s32_type    mg00_2_ff, ph00_2_ff, mg10_2_ff, ph10_2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= vd1_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st2_ff    <= std1_ff[DIV_LAT-1];
         s1_2_ff   <= div_pow2((quo1[0] - quo1[2]) <<< SC_GAIN_SHIFT, DELPT_DIV);
         c1_2_ff   <= div_pow2((quo1[3] - quo1[1]) <<< SC_GAIN_SHIFT, DELPT_DIV);
         s2_2_ff   <= div_pow2((quo1[4] - quo1[6]) <<< SC_GAIN_SHIFT, DELPT_DIV);
         c2_2_ff   <= div_pow2((quo1[7] - quo1[5]) <<< SC_GAIN_SHIFT, DELPT_DIV);
         mg00_2_ff <= quo1[0];
         ph00_2_ff <= quo1[1];
         mg10_2_ff <= quo1[4];
         ph10_2_ff <= quo1[5];
      end
   end

   // ---------------- stage 3: magnitudes ----------------
   logic       v3_ff;
   status_type st3_in, st3_ff;
   s32_type    mag1_in, mag2_in, mag1_ff, mag2_ff;
   s32_type    s1_3_ff, c1_3_ff, s2_3_ff, c2_3_ff;
   s32_type    mg00_3_ff, ph00_3_ff, mg10_3_ff, ph10_3_ff;

   always_comb begin
      mag1_in = mag_approx(c1_2_ff, s1_2_ff);
      mag2_in = mag_approx(c2_2_ff, s2_2_ff);
      st3_in  = st2_ff;
      if (st2_ff == ST_OK && (mag1_in == '0 || mag2_in == '0)) st3_in = ST_ZERO_MAG;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st3_ff    <= st3_in;
         mag1_ff   <= mag1_in;
         mag2_ff   <= mag2_in;
         s1_3_ff   <= s1_2_ff;
         c1_3_ff   <= c1_2_ff;
         s2_3_ff   <= s2_2_ff;
         c2_3_ff   <= c2_2_ff;
         mg00_3_ff <= mg00_2_ff;
         ph00_3_ff <= ph00_2_ff;
         mg10_3_ff <= mg10_2_ff;
         ph10_3_ff <= ph10_2_ff;
      end
   end

   // ---------------- divider bank 2: normalization ----------------
   s32_type    s1n, c1n, s2n, c2n;
   logic       vd2_ff  [DIV_LAT];
   status_type std2_ff [DIV_LAT];
   s32_type    mg00d_ff[DIV_LAT];
   s32_type    ph00d_ff[DIV_LAT];
   s32_type    mg10d_ff[DIV_LAT];
   s32_type    ph10d_ff[DIV_LAT];

   iqm_div u_div_s1 (.clock(clock), .en(en), .num(s1_3_ff <<< RES_SHIFT),
                     .den(mag1_ff), .quo(s1n));
   iqm_div u_div_c1 (.clock(clock), .en(en), .num(c1_3_ff <<< RES_SHIFT),
                     .den(mag1_ff), .quo(c1n));
   iqm_div u_div_s2 (.clock(clock), .en(en), .num(s2_3_ff <<< RES_SHIFT),
                     .den(mag2_ff), .quo(s2n));
   iqm_div u_div_c2 (.clock(clock), .en(en), .num(c2_3_ff <<< RES_SHIFT),
                     .den(mag2_ff), .quo(c2n));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vd2_ff[k] <= 1'b0;
      end else if (en) begin
         vd2_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_LAT; k++) vd2_ff[k] <= vd2_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         std2_ff[0]  <= st3_ff;
         mg00d_ff[0] <= mg00_3_ff;
         ph00d_ff[0] <= ph00_3_ff;
         mg10d_ff[0] <= mg10_3_ff;
         ph10d_ff[0] <= ph10_3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            std2_ff[k]  <= std2_ff[k-1];
            mg00d_ff[k] <= mg00d_ff[k-1];
            ph00d_ff[k] <= ph00d_ff[k-1];
            mg10d_ff[k] <= mg10d_ff[k-1];
            ph10d_ff[k] <= ph10d_ff[k-1];
         end
      end
   end

   // ---------------- stage 4: differences ----------------
   logic       v4_ff;
   status_type st4_ff;
   s32_type    f1_4_ff, f3_4_ff, a1_4_ff, a3_4_ff;
   s32_type    dmg_4_ff, dph_4_ff, dmgn_4_ff;
   s32_type    s1_4_ff, c1_4_ff, mg00_4_ff, ph00_4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= vd2_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st4_ff    <= std2_ff[DIV_LAT-1];
         f1_4_ff   <= c1n - c2n;
         f3_4_ff   <= s1n - s2n;
         a1_4_ff   <= (c1n - c2n) >>> 3;
         a3_4_ff   <= (s1n - s2n) >>> 3;
         dmg_4_ff  <= mg00d_ff[DIV_LAT-1] - mg10d_ff[DIV_LAT-1];
         dph_4_ff  <= ph00d_ff[DIV_LAT-1] - ph10d_ff[DIV_LAT-1];
         dmgn_4_ff <= mg10d_ff[DIV_LAT-1] - mg00d_ff[DIV_LAT-1];
         s1_4_ff   <= s1n;
         c1_4_ff   <= c1n;
         mg00_4_ff <= mg00d_ff[DIV_LAT-1];
         ph00_4_ff <= ph00d_ff[DIV_LAT-1];
      end
   end

   // ---------------- stage 5: products ----------------
   logic       v5_ff;
   status_type st5_ff;
   s32_type    sq1_ff, sq3_ff, pr1_ff, pr2_ff, pr3_ff, pr4_ff;
   s32_type    s1_5_ff, c1_5_ff, mg00_5_ff, ph00_5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st5_ff    <= st4_ff;
         sq1_ff    <= a1_4_ff * a1_4_ff;
         sq3_ff    <= a3_4_ff * a3_4_ff;
         pr1_ff    <= f1_4_ff * dmg_4_ff;
         pr2_ff    <= f3_4_ff * dph_4_ff;
         pr3_ff    <= f3_4_ff * dmgn_4_ff;
         pr4_ff    <= f1_4_ff * dph_4_ff;
         s1_5_ff   <= s1_4_ff;
         c1_5_ff   <= c1_4_ff;
         mg00_5_ff <= mg00_4_ff;
         ph00_5_ff <= ph00_4_ff;
      end
   end

   // ---------------- stage 6: determinant and numerators ----------------
   logic       v6_ff;
   status_type st6_in, st6_ff;
   s32_type    f2_in, f2_ff, mtxn_ff, ptxn_ff;
   s32_type    s1_6_ff, c1_6_ff, mg00_6_ff, ph00_6_ff;

   always_comb begin
      f2_in  = (sq1_ff + sq3_ff) >>> 9;
      st6_in = st5_ff;
      if (st5_ff == ST_OK && f2_in == '0) st6_in = ST_SINGULAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st6_ff    <= st6_in;
         f2_ff     <= f2_in;
         mtxn_ff   <= pr1_ff + pr2_ff;
         ptxn_ff   <= pr3_ff + pr4_ff;
         s1_6_ff   <= s1_5_ff;
         c1_6_ff   <= c1_5_ff;
         mg00_6_ff <= mg00_5_ff;
         ph00_6_ff <= ph00_5_ff;
      end
   end

   // ---------------- divider bank 3: mismatch solve ----------------
   s32_type    mtx, ptx;
   logic       vd3_ff  [DIV_LAT];
   status_type std3_ff [DIV_LAT];
   s32_type    s1d_ff  [DIV_LAT];
   s32_type    c1d_ff  [DIV_LAT];
   s32_type    mg00e_ff[DIV_LAT];
   s32_type    ph00e_ff[DIV_LAT];

   iqm_div u_div_mtx (.clock(clock), .en(en), .num(mtxn_ff), .den(f2_ff), .quo(mtx));
   iqm_div u_div_ptx (.clock(clock), .en(en), .num(ptxn_ff), .den(f2_ff), .quo(ptx));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vd3_ff[k] <= 1'b0;
      end else if (en) begin
         vd3_ff[0] <= v6_ff;
         for (int k = 1; k < DIV_LAT; k++) vd3_ff[k] <= vd3_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         std3_ff[0]  <= st6_ff;
         s1d_ff[0]   <= s1_6_ff;
         c1d_ff[0]   <= c1_6_ff;
         mg00e_ff[0] <= mg00_6_ff;
         ph00e_ff[0] <= ph00_6_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            std3_ff[k]  <= std3_ff[k-1];
            s1d_ff[k]   <= s1d_ff[k-1];
            c1d_ff[k]   <= c1d_ff[k-1];
            mg00e_ff[k] <= mg00e_ff[k-1];
            ph00e_ff[k] <= ph00e_ff[k-1];
         end
      end
   end

   // ---------------- stage 7: receive-side products ----------------
   logic       v7_ff;
   status_type st7_in, st7_ff;
   s32_type    q1_ff, q2_ff, q3_ff, q4_ff;
   s32_type    mtx_7_ff, ptx_7_ff, mg00_7_ff, ph00_7_ff;

   always_comb begin
      st7_in = std3_ff[DIV_LAT-1];
      if (std3_ff[DIV_LAT-1] == ST_OK && mtx == Q15_ONE) st7_in = ST_TX_DIV0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= vd3_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st7_ff    <= st7_in;
         q1_ff     <= c1d_ff[DIV_LAT-1] * mtx;
         q2_ff     <= s1d_ff[DIV_LAT-1] * ptx;
         q3_ff     <= s1d_ff[DIV_LAT-1] * mtx;
         q4_ff     <= c1d_ff[DIV_LAT-1] * ptx;
         mtx_7_ff  <= mtx;
         ptx_7_ff  <= ptx;
         mg00_7_ff <= mg00e_ff[DIV_LAT-1];
         ph00_7_ff <= ph00e_ff[DIV_LAT-1];
      end
   end

   // ---------------- stage 8: receive mismatch ----------------
   logic       v8_ff;
   status_type st8_ff;
   s32_type    mrx_ff, prx_ff, mtx_8_ff, ptx_8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (en) begin
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st8_ff   <= st7_ff;
         mrx_ff   <= mg00_7_ff - div_pow2(q1_ff + q2_ff, RES_SHIFT);
         prx_ff   <= ph00_7_ff + div_pow2(q3_ff - q4_ff, RES_SHIFT);
         mtx_8_ff <= mtx_7_ff;
         ptx_8_ff <= ptx_7_ff;
      end
   end

   // ---------------- stage 9: correction divider operands ----------------
   logic       v9_ff;
   status_type st9_in, st9_ff;
   s32_type    nmrx;
   s32_type    txn_ff, txd_ff, rxn_ff, rxd_ff, ptx_9_ff, prx_9_ff;

   always_comb begin
      nmrx   = -mrx_ff;
      st9_in = st8_ff;
      if (st8_ff == ST_OK && nmrx == Q15_ONE) st9_in = ST_RX_DIV0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else if (en) begin
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st9_ff   <= st9_in;
         txn_ff   <= mtx_8_ff <<< RES_SHIFT;
         txd_ff   <= Q15_ONE - mtx_8_ff;
         rxn_ff   <= nmrx <<< RES_SHIFT;
         rxd_ff   <= Q15_ONE + mrx_ff;
         ptx_9_ff <= ptx_8_ff;
         prx_9_ff <= prx_ff;
      end
   end

   // ---------------- divider bank 4: corrections ----------------
   s32_type    txq, rxq;
   logic       vd4_ff  [DIV_LAT];
   status_type std4_ff [DIV_LAT];
   s32_type    ptxd_ff [DIV_LAT];
   s32_type    prxd_ff [DIV_LAT];

   iqm_div u_div_tx (.clock(clock), .en(en), .num(txn_ff), .den(txd_ff), .quo(txq));
   iqm_div u_div_rx (.clock(clock), .en(en), .num(rxn_ff), .den(rxd_ff), .quo(rxq));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) vd4_ff[k] <= 1'b0;
      end else if (en) begin
         vd4_ff[0] <= v9_ff;
         for (int k = 1; k < DIV_LAT; k++) vd4_ff[k] <= vd4_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         std4_ff[0] <= st9_ff;
         ptxd_ff[0] <= ptx_9_ff;
         prxd_ff[0] <= prx_9_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            std4_ff[k] <= std4_ff[k-1];
            ptxd_ff[k] <= ptxd_ff[k-1];
            prxd_ff[k] <= prxd_ff[k-1];
         end
      end
   end

   // ---------------- stage 10: pack and output register ----------------
   status_type st_fin;
   corr_type   tx_in, rx_in, tx_ff, rx_ff;
   status_type st10_ff;
   logic       v10_ff;

   always_comb begin
      st_fin = std4_ff[DIV_LAT-1];
      tx_in  = '0;
      rx_in  = '0;
      if (st_fin == ST_OK || st_fin == ST_RX_DIV0) begin
         tx_in = pack_corr(txq, -ptxd_ff[DIV_LAT-1]);
      end
      if (st_fin == ST_OK) begin
         rx_in = pack_corr(rxq, -prxd_ff[DIV_LAT-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else if (en) begin
         v10_ff <= vd4_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st10_ff <= st_fin;
         tx_ff   <= tx_in;
         rx_ff   <= rx_in;
      end
   end

   // whole pipeline advances unless a finished item is held
   assign en                = !v10_ff || !rsp_stall;
   assign req_stall         = !en;
   assign rsp_valid         = v10_ff;
   assign rsp_tx_correction = tx_ff;
   assign rsp_rx_correction = rx_ff;
   assign rsp_status        = st10_ff;

   // ---------------- assertions ----------------
   a_tx_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && st10_ff != ST_OK && st10_ff != ST_RX_DIV0) |-> (rsp_tx_correction == '0))
      else $error("tx correction not cleared on failure");

   a_rx_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && st10_ff != ST_OK) |-> (rsp_rx_correction == '0))
      else $error("rx correction not cleared on failure");

   a_q_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tx_correction[13:7] != 7'h40 && rsp_rx_correction[13:7] != 7'h40))
      else $error("correction q field outside clamp");

   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(st10_ff)))
      else $error("held item lost inside pipeline");

endmodule
